>>> design/hss_pkg.sv
// Shared types, widths and constants for the heading source selector.
package hss_pkg;

  localparam int NUM_ENTRIES = 3;
  localparam int ENT_IDX_W   = 2;

  localparam int YAW_IN_W  = 32;
  localparam int YAW_W     = 16;
  localparam int TIME_W    = 40;
  localparam int OTIME_W   = 39;
  localparam int BOOT_W    = 32;
  localparam int AGE_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 1;

  localparam int QUOT_W    = 16;
  localparam int RECIP_SH  = 46;
  localparam int RECIP_W   = 31;
  localparam int PROD_W    = YAW_IN_W + RECIP_W;
  localparam int REM_W     = 17;

  localparam logic [RECIP_W-1:0] YAW_RECIP = 31'd1954687338;
  localparam logic [YAW_W-1:0]   YAW_TURN  = 16'd36000;

  localparam logic [CFG_DATA_W-1:0] MAX_AGE_RST  = 16'd2000;
  localparam logic [CFG_DATA_W-1:0] ROLLBACK_RST = 16'd1000;

  localparam logic [CFG_ADDR_W-1:0] REG_MAX_AGE  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ROLLBACK = 1'd1;

  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [ENT_IDX_W-1:0] SRC_QUAT = 2'd0;
  localparam logic [ENT_IDX_W-1:0] SRC_ATT  = 2'd1;
  localparam logic [ENT_IDX_W-1:0] SRC_HLAT = 2'd2;
  localparam logic [ENT_IDX_W-1:0] SRC_NONE = 2'd3;

  localparam int IN_TUSER_W  = 3;
  localparam int IN_CMD_BIT  = 0;
  localparam int IN_SRC_LSB  = 1;
  localparam int IN_YAW_LSB  = 0;
  localparam int IN_RECV_LSB = 32;
  localparam int IN_BP_BIT   = 72;
  localparam int IN_BOOT_LSB = 73;
  localparam int IN_NOW_LSB  = 105;
  localparam int IN_TDATA_W  = 152;

  localparam int OUT_ACC_BIT   = 0;
  localparam int OUT_HV_BIT    = 1;
  localparam int OUT_YAW_LSB   = 2;
  localparam int OUT_SRC_LSB   = 18;
  localparam int OUT_TIME_LSB  = 20;
  localparam int OUT_AGE_LSB   = 59;
  localparam int OUT_FIELDS_W  = 75;
  localparam int OUT_TDATA_W   = 80;

  typedef struct packed {
    logic                 cmd;
    logic [ENT_IDX_W-1:0] source;
    logic [YAW_IN_W-1:0]  yaw_centideg;
    logic [TIME_W-1:0]    received_ms;
    logic                 boot_present;
    logic [BOOT_W-1:0]    boot_ms;
    logic [TIME_W-1:0]    now_ms;
  } hss_req_t;

  typedef struct packed {
    logic                neg;
    logic [YAW_IN_W-1:0] mag;
    logic [QUOT_W-1:0]   quot;
  } hss_wrap_t;

  typedef struct packed {
    logic                 accepted;
    logic                 heading_valid;
    logic [YAW_W-1:0]     heading_yaw;
    logic [ENT_IDX_W-1:0] heading_source;
    logic [OTIME_W-1:0]   sample_time_ms;
    logic [AGE_W-1:0]     sample_age_ms;
  } hss_rsp_t;

endpackage

>>> design/hss_yaw_quot.sv
// Yaw magnitude and quotient estimate by 36000 through a reciprocal multiply.
module hss_yaw_quot (
  input  logic [hss_pkg::YAW_IN_W-1:0] yaw,
  output hss_pkg::hss_wrap_t           wrap
);

  logic [hss_pkg::YAW_IN_W-1:0] mag;
  logic [hss_pkg::PROD_W-1:0]   prod;

  assign mag  = yaw[hss_pkg::YAW_IN_W-1] ? (~yaw + 32'd1) : yaw;
  assign prod = {{hss_pkg::RECIP_W{1'b0}}, mag} *
                {{hss_pkg::YAW_IN_W{1'b0}}, hss_pkg::YAW_RECIP};

  assign wrap.neg  = yaw[hss_pkg::YAW_IN_W-1];
  assign wrap.mag  = mag;
  assign wrap.quot = prod[hss_pkg::RECIP_SH +: hss_pkg::QUOT_W];

endmodule

>>> design/hss_yaw_rem.sv
// Remainder correction and sign fold of the yaw into 0..35999.
module hss_yaw_rem (
  input  hss_pkg::hss_wrap_t        wrap,
  output logic [hss_pkg::YAW_W-1:0] yaw_wrapped
);

  logic [hss_pkg::YAW_IN_W-1:0] qmul;
  logic [hss_pkg::YAW_IN_W:0]   diff;
  logic [hss_pkg::REM_W-1:0]    rem;
  logic [hss_pkg::REM_W-1:0]    rem_fix;
  logic [hss_pkg::REM_W-1:0]    turn;

  assign turn    = {1'b0, hss_pkg::YAW_TURN};
  assign qmul    = {16'd0, wrap.quot} * {16'd0, hss_pkg::YAW_TURN};
  assign diff    = {1'b0, wrap.mag} - {1'b0, qmul};
  assign rem     = diff[hss_pkg::REM_W-1:0];
  assign rem_fix = (rem >= turn) ? (rem - turn) : rem;

  always_comb begin
    if (wrap.neg && (rem_fix != '0)) begin
      yaw_wrapped = hss_pkg::YAW_TURN - rem_fix[hss_pkg::YAW_W-1:0];
    end else begin
      yaw_wrapped = rem_fix[hss_pkg::YAW_W-1:0];
    end
  end

endmodule

>>> design/hss_entry_table.sv
// Per-source heading entries, store checks, fresh selection and config registers.
module hss_entry_table (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [hss_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [hss_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             req_fire,
  input  hss_pkg::hss_req_t                req,
  input  logic [hss_pkg::YAW_W-1:0]        yaw_wrapped,
  output hss_pkg::hss_rsp_t                rsp
);

  localparam int N = hss_pkg::NUM_ENTRIES;

  logic [N-1:0]                   valid_r, valid_nxt;
  logic [N-1:0]                   bp_r;
  logic [hss_pkg::YAW_W-1:0]      yaw_r [N];
  logic [hss_pkg::TIME_W-1:0]     arr_r [N];
  logic [hss_pkg::BOOT_W-1:0]     bt_r  [N];
  logic [hss_pkg::CFG_DATA_W-1:0] max_age_r, rollback_r;

  logic [hss_pkg::ENT_IDX_W-1:0]  sidx;
  logic [N-1:0]                   sel_hot;
  logic                           e_valid, e_bp, boot_chk, rollback, wipe;
  logic                           src_none, older, reject, store_ok, do_write;
  logic [hss_pkg::TIME_W-1:0]     e_arr;
  logic [hss_pkg::BOOT_W-1:0]     e_bt, fwd, back;

  logic [hss_pkg::TIME_W:0]       age [N];
  logic [N-1:0]                   fresh;
  logic [hss_pkg::BOOT_W-1:0]     boot_gap;
  logic                           newer_att, found;
  logic [hss_pkg::ENT_IDX_W-1:0]  sel;

  // store checks
  assign src_none = (req.source == hss_pkg::SRC_NONE);
  assign sidx     = src_none ? hss_pkg::SRC_QUAT : req.source;
  assign e_valid  = valid_r[sidx];
  assign e_bp     = bp_r[sidx];
  assign e_arr    = arr_r[sidx];
  assign e_bt     = bt_r[sidx];
  assign fwd      = req.boot_ms - e_bt;
  assign back     = e_bt - req.boot_ms;
  assign boot_chk = e_valid && e_bp && req.boot_present;
  assign rollback = boot_chk && fwd[hss_pkg::BOOT_W-1];
  assign older    = e_valid && ($signed(req.received_ms) < $signed(e_arr));
  assign reject   = src_none || req.received_ms[hss_pkg::TIME_W-1] || older ||
                    (boot_chk && (fwd == '0)) ||
                    (rollback && (back <= {16'd0, rollback_r}));
  assign store_ok = !reject;
  assign wipe     = rollback;
  assign do_write = req_fire && (req.cmd == hss_pkg::CMD_STORE) && store_ok;

  always_comb begin
    sel_hot = '0;
    sel_hot[sidx] = 1'b1;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (do_write) begin
      valid_nxt = wipe ? sel_hot : (valid_r | sel_hot);
    end
  end

  // freshness and selection
  always_comb begin
    for (int i = 0; i < N; i++) begin
      age[i]   = {req.now_ms[hss_pkg::TIME_W-1], req.now_ms} -
                 {arr_r[i][hss_pkg::TIME_W-1], arr_r[i]};
      fresh[i] = valid_r[i] && !age[i][hss_pkg::TIME_W] &&
                 (age[i][hss_pkg::TIME_W-1:0] <= {24'd0, max_age_r});
    end
  end

  assign boot_gap  = bt_r[hss_pkg::SRC_ATT] - bt_r[hss_pkg::SRC_QUAT];
  assign newer_att = (bp_r[hss_pkg::SRC_ATT] && bp_r[hss_pkg::SRC_QUAT]) ?
                     ((boot_gap != '0) && !boot_gap[hss_pkg::BOOT_W-1]) :
                     ($signed(arr_r[hss_pkg::SRC_ATT]) > $signed(arr_r[hss_pkg::SRC_QUAT]));

  always_comb begin
    found = 1'b1;
    sel   = hss_pkg::SRC_QUAT;
    if (fresh[hss_pkg::SRC_QUAT] && fresh[hss_pkg::SRC_ATT]) begin
      sel = newer_att ? hss_pkg::SRC_ATT : hss_pkg::SRC_QUAT;
    end else if (fresh[hss_pkg::SRC_QUAT]) begin
      sel = hss_pkg::SRC_QUAT;
    end else if (fresh[hss_pkg::SRC_ATT]) begin
      sel = hss_pkg::SRC_ATT;
    end else if (fresh[hss_pkg::SRC_HLAT]) begin
      sel = hss_pkg::SRC_HLAT;
    end else begin
      found = 1'b0;
    end
  end

  always_comb begin
    rsp = '0;
    if (req.cmd == hss_pkg::CMD_STORE) begin
      rsp.accepted = store_ok;
    end else if (found) begin
      rsp.heading_valid  = 1'b1;
      rsp.heading_yaw    = yaw_r[sel];
      rsp.heading_source = sel;
      rsp.sample_time_ms = arr_r[sel][hss_pkg::OTIME_W-1:0];
      rsp.sample_age_ms  = age[sel][hss_pkg::AGE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      max_age_r  <= hss_pkg::MAX_AGE_RST;
      rollback_r <= hss_pkg::ROLLBACK_RST;
    end else begin
      valid_r <= valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_addr)
          hss_pkg::REG_MAX_AGE:  max_age_r  <= cfg_wdata;
          hss_pkg::REG_ROLLBACK: rollback_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_r <= '0;
    end else if (do_write) begin
      bp_r[sidx] <= req.boot_present;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      yaw_r[sidx] <= yaw_wrapped;
      arr_r[sidx] <= req.received_ms;
      bt_r[sidx]  <= req.boot_ms;
    end
  end

endmodule

>>> design/heading_source_selector.sv
// Heading source selector: one request per cycle while the result side does not stall.
// Each request passes an input register, a stage that holds the yaw quotient estimate, and
// the output register; entry checks, updates and fresh selection all happen in the last
// stage, so a request always sees the entries left by the one before it. Throughput is one
// request per clock unless the result side stalls; any stall there holds the whole pipeline.
// The yaw wrap uses a 32x31 reciprocal multiply. No clearing pass follows reset.
module heading_source_selector (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // yaw_centideg, received_ms, boot_present, boot_ms, now_ms, zero pad
  input  logic [hss_pkg::IN_TDATA_W-1:0]     in_tdata,
  // cmd, source
  input  logic [hss_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // accepted, heading_valid, heading_yaw, heading_source, sample_time_ms,
  // sample_age_ms, zero pad
  output logic [hss_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_wr_en,
  input  logic [hss_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [hss_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic               advance;
  logic               a_valid_r, b_valid_r, out_valid_r;
  hss_pkg::hss_req_t  in_req, a_req_r, b_req_r;
  hss_pkg::hss_wrap_t a_wrap, b_wrap_r;
  hss_pkg::hss_rsp_t  rsp, out_rsp_r;
  logic [hss_pkg::YAW_W-1:0] yaw_wrapped;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance;

  always_comb begin
    in_req.cmd          = in_tuser[hss_pkg::IN_CMD_BIT];
    in_req.source       = in_tuser[hss_pkg::IN_SRC_LSB +: hss_pkg::ENT_IDX_W];
    in_req.yaw_centideg = in_tdata[hss_pkg::IN_YAW_LSB +: hss_pkg::YAW_IN_W];
    in_req.received_ms  = in_tdata[hss_pkg::IN_RECV_LSB +: hss_pkg::TIME_W];
    in_req.boot_present = in_tdata[hss_pkg::IN_BP_BIT];
    in_req.boot_ms      = in_tdata[hss_pkg::IN_BOOT_LSB +: hss_pkg::BOOT_W];
    in_req.now_ms       = in_tdata[hss_pkg::IN_NOW_LSB +: hss_pkg::TIME_W];
  end

  hss_yaw_quot u_quot (
    .yaw  (a_req_r.yaw_centideg),
    .wrap (a_wrap)
  );

  hss_yaw_rem u_rem (
    .wrap        (b_wrap_r),
    .yaw_wrapped (yaw_wrapped)
  );

  hss_entry_table u_tbl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .req_fire    (b_valid_r && advance),
    .req         (b_req_r),
    .yaw_wrapped (yaw_wrapped),
    .rsp         (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      a_valid_r   <= in_tvalid;
      b_valid_r   <= a_valid_r;
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_req_r   <= in_req;
      b_req_r   <= a_req_r;
      b_wrap_r  <= a_wrap;
      out_rsp_r <= rsp;
    end
  end

  assign out_tvalid = out_valid_r;

  always_comb begin
    out_tdata = '0;
    out_tdata[hss_pkg::OUT_ACC_BIT]  = out_rsp_r.accepted;
    out_tdata[hss_pkg::OUT_HV_BIT]   = out_rsp_r.heading_valid;
    out_tdata[hss_pkg::OUT_YAW_LSB +: hss_pkg::YAW_W]       = out_rsp_r.heading_yaw;
    out_tdata[hss_pkg::OUT_SRC_LSB +: hss_pkg::ENT_IDX_W]   = out_rsp_r.heading_source;
    out_tdata[hss_pkg::OUT_TIME_LSB +: hss_pkg::OTIME_W]    = out_rsp_r.sample_time_ms;
    out_tdata[hss_pkg::OUT_AGE_LSB +: hss_pkg::AGE_W]       = out_rsp_r.sample_age_ms;
  end

endmodule

>>> design/hss_checker.sv
// Port-level checks for the heading source selector, bound to the top level.
module hss_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [hss_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic                          acc, hv;
  logic [hss_pkg::YAW_W-1:0]     yaw;
  logic [hss_pkg::ENT_IDX_W-1:0] src;

  assign acc = out_tdata[hss_pkg::OUT_ACC_BIT];
  assign hv  = out_tdata[hss_pkg::OUT_HV_BIT];
  assign yaw = out_tdata[hss_pkg::OUT_YAW_LSB +: hss_pkg::YAW_W];
  assign src = out_tdata[hss_pkg::OUT_SRC_LSB +: hss_pkg::ENT_IDX_W];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(acc && hv))
    else $error("result flags both store and query outcome");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !hv |->
      out_tdata[hss_pkg::OUT_FIELDS_W-1:hss_pkg::OUT_YAW_LSB] == '0)
    else $error("heading fields set without a selected sample");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && hv |-> (yaw < hss_pkg::YAW_TURN) && (src != hss_pkg::SRC_NONE))
    else $error("selected heading out of range");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind heading_source_selector hss_checker u_hss_checker (.*);

>>> dv/tb.sv
// Self-checking testbench for heading_source_selector: directed and random requests.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hss_pkg::*;

  localparam longint TURN_CD   = 36000;
  localparam int     IDLE_STOP = 4000;
  localparam int     EPISODES  = 8;
  localparam int     EP_ITEMS  = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [IN_TUSER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  heading_source_selector uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  bit               stored_valid[NUM_ENTRIES];
  logic [YAW_W-1:0] stored_yaw[NUM_ENTRIES];
  longint           stored_arr[NUM_ENTRIES];
  bit               stored_has_boot[NUM_ENTRIES];
  logic [BOOT_W-1:0] stored_boot[NUM_ENTRIES];
  logic [CFG_DATA_W-1:0] age_limit = MAX_AGE_RST;
  logic [CFG_DATA_W-1:0] rollback_limit = ROLLBACK_RST;

  hss_rsp_t heading_due[$];
  int err_cnt = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  longint cur_time;
  logic [BOOT_W-1:0] boot_clk;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void wipe_entries();
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      stored_valid[i] = 1'b0;
      stored_yaw[i] = '0;
      stored_arr[i] = 0;
      stored_has_boot[i] = 1'b0;
      stored_boot[i] = '0;
    end
  endfunction

  function automatic hss_rsp_t compute_heading(hss_req_t r);
    hss_rsp_t rsp;
    longint arr, now, yaw, rem, lim, d;
    int src, sel;
    bit ok, newer;
    logic [BOOT_W-1:0] fwd, back;
    rsp = '0;
    if (r.cmd == CMD_STORE) begin
      src = r.source;
      arr = $signed(r.received_ms);
      ok = (src < NUM_ENTRIES) && (arr >= 0);
      if (ok && stored_valid[src] && arr < stored_arr[src]) ok = 1'b0;
      if (ok && stored_valid[src] && stored_has_boot[src] && r.boot_present) begin
        fwd = r.boot_ms - stored_boot[src];
        if (fwd == '0) begin
          ok = 1'b0;
        end else if (fwd[BOOT_W-1]) begin
          back = stored_boot[src] - r.boot_ms;
          if (back <= {16'd0, rollback_limit}) ok = 1'b0;
          else wipe_entries();
        end
      end
      if (ok) begin
        yaw = $signed(r.yaw_centideg);
        rem = yaw % TURN_CD;
        if (rem < 0) rem += TURN_CD;
        stored_valid[src] = 1'b1;
        stored_yaw[src] = rem[YAW_W-1:0];
        stored_arr[src] = arr;
        stored_has_boot[src] = r.boot_present;
        stored_boot[src] = r.boot_ms;
      end
      rsp.accepted = ok;
    end else begin
      now = $signed(r.now_ms);
      lim = age_limit;
      sel = -1;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (!stored_valid[i] || now < stored_arr[i] || now - stored_arr[i] > lim) continue;
        if (sel < 0) begin
          sel = i;
        end else if (i != SRC_HLAT) begin
          if (stored_has_boot[i] && stored_has_boot[sel]) begin
            fwd = stored_boot[i] - stored_boot[sel];
            newer = (fwd != '0) && !fwd[BOOT_W-1];
          end else begin
            newer = stored_arr[i] > stored_arr[sel];
          end
          if (newer) sel = i;
        end
      end
      if (sel >= 0) begin
        d = now - stored_arr[sel];
        rsp.heading_valid = 1'b1;
        rsp.heading_yaw = stored_yaw[sel];
        rsp.heading_source = sel[ENT_IDX_W-1:0];
        rsp.sample_time_ms = stored_arr[sel][OTIME_W-1:0];
        rsp.sample_age_ms = d[AGE_W-1:0];
      end
    end
    return rsp;
  endfunction

  function automatic logic [TIME_W-1:0] rand40();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[TIME_W-1:0];
  endfunction

  function automatic int pick_gap(bit en);
    int x;
    x = $urandom_range(0, 99);
    if (!en || x < 60) return 0;
    if (x < 90) return $urandom_range(1, 3);
    if (x < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic hss_req_t make_store(logic [ENT_IDX_W-1:0] src, logic [YAW_IN_W-1:0] yaw,
                                          longint recv, bit bp, logic [BOOT_W-1:0] boot);
    hss_req_t r;
    r.cmd = CMD_STORE;
    r.source = src;
    r.yaw_centideg = yaw;
    r.received_ms = recv[TIME_W-1:0];
    r.boot_present = bp;
    r.boot_ms = boot;
    r.now_ms = rand40();
    return r;
  endfunction

  function automatic hss_req_t make_query(longint now);
    hss_req_t r;
    r.cmd = CMD_QUERY;
    r.source = ENT_IDX_W'($urandom_range(0, 3));
    r.yaw_centideg = $urandom;
    r.received_ms = rand40();
    r.boot_present = 1'($urandom_range(0, 1));
    r.boot_ms = $urandom;
    r.now_ms = now[TIME_W-1:0];
    return r;
  endfunction

  task automatic send_req(input hss_req_t r);
    int gap;
    logic [IN_TDATA_W-1:0] d;
    gap = pick_gap(tx_idle_en);
    d = '0;
    d[IN_YAW_LSB +: YAW_IN_W] = r.yaw_centideg;
    d[IN_RECV_LSB +: TIME_W] = r.received_ms;
    d[IN_BP_BIT] = r.boot_present;
    d[IN_BOOT_LSB +: BOOT_W] = r.boot_ms;
    d[IN_NOW_LSB +: TIME_W] = r.now_ms;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= {r.source, r.cmd};
    do @(posedge clk); while (!in_tready);
    heading_due.push_back(compute_heading(r));
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (heading_due.size() != 0);
  endtask

  task automatic write_regs(input logic [CFG_DATA_W-1:0] age, input logic [CFG_DATA_W-1:0] rlim);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_addr <= REG_MAX_AGE;
    cfg_wdata <= age;
    @(posedge clk);
    age_limit = age;
    @(negedge clk);
    cfg_addr <= REG_ROLLBACK;
    cfg_wdata <= rlim;
    @(posedge clk);
    rollback_limit = rlim;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_idle_queries();
    send_req(make_query(0));
    send_req(make_query(-64'sd549755813888));
    send_req(make_query(64'sd549755813887));
  endtask

  task automatic test_store_rejects();
    send_req(make_store(SRC_NONE, 32'd100, 100, 1'b0, '0));
    send_req(make_store(SRC_QUAT, 32'd100, -1, 1'b1, 32'd5));
    send_req(make_store(SRC_ATT, 32'd100, -64'sd549755813888, 1'b0, '0));
    send_req(make_store(SRC_QUAT, 32'd0, 0, 1'b0, '0));
  endtask

  task automatic test_yaw_wrap();
    send_req(make_store(SRC_QUAT, 32'h8000_0000, 10, 1'b0, '0));
    send_req(make_query(10));
    send_req(make_store(SRC_QUAT, 32'h7FFF_FFFF, 20, 1'b0, '0));
    send_req(make_query(20));
    send_req(make_store(SRC_QUAT, 32'hFFFF_FFFF, 30, 1'b0, '0));
    send_req(make_query(30));
    send_req(make_store(SRC_QUAT, 32'd36000, 40, 1'b0, '0));
    send_req(make_query(40));
  endtask

  task automatic test_boot_order();
    send_req(make_store(SRC_ATT, 32'd1234, 100, 1'b1, 32'hFFFF_FFF0));
    send_req(make_store(SRC_ATT, 32'd2345, 101, 1'b1, 32'h0000_0010));
    send_req(make_store(SRC_ATT, 32'd3456, 102, 1'b1, 32'h0000_0010));
    send_req(make_store(SRC_ATT, 32'd4567, 90, 1'b1, 32'h0000_0020));
    send_req(make_store(SRC_ATT, 32'd5678, 103, 1'b1, 32'h0000_0010 - 32'd1000));
    send_req(make_store(SRC_ATT, 32'd6789, 104, 1'b1, 32'h0000_0010 - 32'd1001));
    send_req(make_query(104));
  endtask

  task automatic test_source_priority();
    send_req(make_store(SRC_QUAT, 32'd100, 200, 1'b1, 32'd500));
    send_req(make_store(SRC_ATT, 32'd200, 150, 1'b1, 32'd600));
    send_req(make_store(SRC_HLAT, 32'd300, 300, 1'b0, '0));
    send_req(make_query(299));
    send_req(make_query(2150));
    send_req(make_query(2151));
    send_req(make_query(2201));
  endtask

  task automatic test_random_traffic();
    hss_req_t r;
    int src, x, pick;
    longint now, anchor, lim;
    logic [BOOT_W-1:0] back;
    logic [YAW_IN_W-1:0] yaw;
    for (int ep = 0; ep < EPISODES; ep++) begin
      case (ep)
        0: write_regs(16'd2000, 16'd1000);
        1: write_regs(16'd0, 16'd0);
        2: write_regs(16'hFFFF, 16'hFFFF);
        3: write_regs(16'd1, 16'hFFFF);
        4: write_regs(16'hFFFF, 16'd0);
        default: write_regs(CFG_DATA_W'($urandom_range(0, 5000)),
                            CFG_DATA_W'($urandom_range(0, 5000)));
      endcase
      tx_idle_en = (ep % 3 != 0);
      rx_idle_en = (ep % 3 != 0);
      cur_time = (longint'(ep) << 36) + (longint'({$urandom, $urandom}) & 64'h7_FFFF_FFFF);
      boot_clk = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255) : $urandom;
      lim = age_limit;
      for (int i = 0; i < EP_ITEMS; i++) begin
        if (ep == 4 && i == EP_ITEMS / 2) drain();
        x = $urandom_range(0, 99);
        src = $urandom_range(0, 2);
        yaw = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 71999) - 36000 : $urandom;
        if (x >= 45 && x < 52 && !(stored_valid[src] && stored_has_boot[src])) x = 0;
        if (x < 45) begin
          pick = $urandom_range(0, 400);
          cur_time += pick;
          boot_clk += pick;
          r = make_store(ENT_IDX_W'(src), yaw, cur_time, $urandom_range(0, 9) != 0, boot_clk);
        end else if (x < 52) begin
          case ($urandom_range(0, 4))
            0: back = '0;
            1: back = (rollback_limit == 0) ? '0 : $urandom_range(1, rollback_limit);
            2: back = rollback_limit;
            3: back = rollback_limit + 1;
            default: back = rollback_limit + 1 + $urandom_range(0, 100000);
          endcase
          boot_clk = stored_boot[src] - back;
          r = make_store(ENT_IDX_W'(src), yaw, cur_time, 1'b1, boot_clk);
        end else if (x < 60) begin
          case ($urandom_range(0, 3))
            0: r = make_store(SRC_NONE, yaw, cur_time, 1'b1, boot_clk + 1);
            1: r = make_store(ENT_IDX_W'(src), yaw,
                              longint'(rand40() | 40'h80_0000_0000) - (64'sd1 << 40),
                              1'b1, boot_clk + 1);
            2: r = make_store(ENT_IDX_W'(src), yaw, cur_time - $urandom_range(1, 2000), 1'b1,
                              boot_clk + 1);
            default: r = make_store(ENT_IDX_W'(src), yaw, cur_time, 1'b1, $urandom);
          endcase
        end else begin
          anchor = stored_valid[src] ? stored_arr[src] : cur_time;
          case ($urandom_range(0, 6))
            0: now = anchor;
            1: now = anchor + lim;
            2: now = anchor + lim + 1;
            3: now = anchor - 1;
            4: now = anchor + $urandom_range(0, age_limit);
            5: now = cur_time + $urandom_range(0, 3000);
            default: now = rand40();
          endcase
          r = make_query(now);
        end
        send_req(r);
      end
    end
  endtask

  task automatic test_arrival_ceiling();
    send_req(make_store(SRC_HLAT, 32'd17999, 64'sd549755813887, 1'b0, '0));
    send_req(make_store(SRC_QUAT, 32'hDEAD_BEEF, 64'sd549755813887, 1'b1, 32'hFFFF_FFFF));
    send_req(make_query(64'sd549755813887));
    send_req(make_query(64'sd549755813887 - age_limit));
  endtask

  task automatic check_field(input string fname, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      err_cnt++;
      if (err_cnt <= 100)
        $display("%0t %s: expected %0h, actual %0h", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    hss_rsp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (heading_due.size() == 0) begin
        err_cnt++;
        $display("%0t result: expected none, actual %0h", $time, out_tdata);
      end else begin
        want = heading_due.pop_front();
        check_field("accepted", want.accepted, out_tdata[OUT_ACC_BIT]);
        check_field("heading_valid", want.heading_valid, out_tdata[OUT_HV_BIT]);
        check_field("heading_yaw", want.heading_yaw, out_tdata[OUT_YAW_LSB +: YAW_W]);
        check_field("heading_source", want.heading_source,
                    out_tdata[OUT_SRC_LSB +: ENT_IDX_W]);
        check_field("sample_time_ms", want.sample_time_ms,
                    out_tdata[OUT_TIME_LSB +: OTIME_W]);
        check_field("sample_age_ms", want.sample_age_ms, out_tdata[OUT_AGE_LSB +: AGE_W]);
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!rx_idle_en || $urandom_range(0, 99) < 70) begin
      out_tready <= 1'b1;
    end else begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 3);
      out_tready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_STOP) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    wipe_entries();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_idle_queries();
    test_store_rejects();
    test_yaw_wrap();
    test_boot_order();
    test_source_priority();
    test_random_traffic();
    test_arrival_ceiling();
    drain();
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
